FILE: rtl/core/mtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Millisecond timer table package
// Types, codes and sizes of the timer table and its slot memory.
// ----------------------------------------------------------------------------
package mtt_pkg;

  // Number of timer slots and the most expiries one tick may report.
  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

  localparam int TIME_W  = 48;
  localparam int IDENT_W = 32;
  localparam int DELAY_W = 24;
  localparam int WAIT_W  = 10;

  localparam logic [WAIT_W-1:0] EMPTY_WAIT_MS = WAIT_W'(100);
  localparam logic [WAIT_W-1:0] MAX_WAIT_MS   = WAIT_W'(1000);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [DELAY_W-1:0] interval;
    logic               repeat_req;
    logic [IDENT_W-1:0] cancel_id;
  } item_t;

  typedef struct packed {
    logic [IDENT_W-1:0] timer_ref;
    logic               expired;
    logic [1:0]         status;
    logic [WAIT_W-1:0]  next_wait_ms;
    logic               last;
  } result_t;

  // One entry of the slot memory. A period of zero marks a one-shot timer.
  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [TIME_W-1:0]  expiry;
    logic [DELAY_W-1:0] period;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_CLAMP,
    S_EMIT
  } state_t;

endpackage

FILE: rtl/core/millisecond_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Millisecond timer table
// A table of one-shot and periodic timers advanced by millisecond ticks.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the item's last result has been issued. Every item sweeps the slot
// memory once through a three-stage pipeline (read, update, nearest-expiry
// compare). A tick that fires timers makes a second sweep that reads back
// the fired ids. The sweeps are set by the single read port of the slot
// memory. Results are shown for exactly one cycle with result_valid high;
// the receiver cannot hold them off and must take each one as it comes.
// last marks the final result of an item, and every result of a tick
// carries the same wait value, taken after all of that tick's expiries.
module millisecond_timer_table
  import mtt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output result_t result,
  output logic    result_valid
);

  // Control state.
  state_t                 state, state_next;
  logic [CNT_W-1:0]       idx, idx_next;
  logic                   rd_vld, rd_vld_next;
  logic                   ev_vld, ev_vld_next;
  logic [TIMER_SLOTS-1:0] slot_valid, slot_valid_next;
  logic [TIME_W-1:0]      clock_ms, clock_ms_next;
  logic [IDENT_W-1:0]     next_ident, next_ident_next;
  logic                   result_valid_next;

  // Per-item working registers.
  item_t                  cur, cur_next;
  logic [IDX_W-1:0]       rd_idx, rd_idx_next;
  logic                   post_valid, post_valid_next;
  logic [TIME_W-1:0]      post_exp, post_exp_next;
  logic [TIME_W-1:0]      nearest, nearest_next;
  logic                   any_valid, any_valid_next;
  logic [TIMER_SLOTS-1:0] fired_mask, fired_mask_next;
  logic [FIRE_W-1:0]      fire_cnt, fire_cnt_next;
  logic                   found, found_next;
  logic [IDENT_W-1:0]     result_id, result_id_next;
  logic [TIME_W-1:0]      diff, diff_next;
  logic                   due_now, due_now_next;
  logic [WAIT_W-1:0]      wait_ms, wait_ms_next;
  result_t                result_next;

  // Slot memory ports.
  logic                   ram_we;
  slot_t                  ram_wdata;
  slot_t                  ram_rdata;
  logic [IDX_W-1:0]       ram_raddr;

  // The shared expiry adder: clock plus the add delay or the slot's period.
  logic [DELAY_W-1:0]     add_term;
  logic [TIME_W-1:0]      sum_exp;

  logic                   issue;
  logic                   slot_is_valid;
  logic [TIMER_SLOTS-1:0] rd_bit;
  logic [TIME_W:0]        sub_full;
  logic [WAIT_W-1:0]      wait_value;

  mtt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TIMER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign ram_raddr = idx[IDX_W-1:0];
  assign issue     = ((state == S_SCAN) || (state == S_EMIT)) &&
                     (idx < CNT_W'(TIMER_SLOTS));
  assign add_term  = (cur.opcode == OP_ADD) ? cur.interval : ram_rdata.period;
  assign sum_exp   = clock_ms + TIME_W'(add_term);
  assign slot_is_valid = slot_valid[rd_idx];
  assign rd_bit    = TIMER_SLOTS'(1) << rd_idx;
  assign sub_full  = {1'b0, nearest} - {1'b0, clock_ms};

  // Wait until the nearest expiry, clamped to the reporting range.
  always_comb begin
    if (!any_valid) begin
      wait_value = EMPTY_WAIT_MS;
    end else if (due_now) begin
      wait_value = '0;
    end else if (diff > TIME_W'(MAX_WAIT_MS)) begin
      wait_value = MAX_WAIT_MS;
    end else begin
      wait_value = diff[WAIT_W-1:0];
    end
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    rd_vld_next       = issue;
    ev_vld_next       = 1'b0;
    slot_valid_next   = slot_valid;
    clock_ms_next     = clock_ms;
    next_ident_next   = next_ident;
    result_valid_next = 1'b0;
    cur_next          = cur;
    rd_idx_next       = issue ? idx[IDX_W-1:0] : rd_idx;
    post_valid_next   = post_valid;
    post_exp_next     = post_exp;
    nearest_next      = nearest;
    any_valid_next    = any_valid;
    fired_mask_next   = fired_mask;
    fire_cnt_next     = fire_cnt;
    found_next        = found;
    result_id_next    = result_id;
    diff_next         = diff;
    due_now_next      = due_now;
    wait_ms_next      = wait_ms;
    result_next       = result;
    ram_we            = 1'b0;
    ram_wdata         = ram_rdata;

    if (issue) begin
      idx_next = idx + CNT_W'(1);
    end

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cur_next        = item;
          idx_next        = '0;
          any_valid_next  = 1'b0;
          nearest_next    = '0;
          fired_mask_next = '0;
          fire_cnt_next   = '0;
          found_next      = 1'b0;
          if (item.opcode == OP_TICK) begin
            clock_ms_next = clock_ms + TIME_W'(1);
          end
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        // Update stage: act on the slot read in the previous cycle.
        if (rd_vld) begin
          ev_vld_next     = 1'b1;
          post_valid_next = slot_is_valid;
          post_exp_next   = ram_rdata.expiry;
          unique case (cur.opcode)
            OP_ADD: begin
              if (!slot_is_valid && !found) begin
                ram_we           = 1'b1;
                ram_wdata.ident  = next_ident;
                ram_wdata.expiry = sum_exp;
                ram_wdata.period = (cur.repeat_req && (cur.interval != '0)) ?
                                   cur.interval : '0;
                slot_valid_next  = slot_valid | rd_bit;
                found_next       = 1'b1;
                result_id_next   = next_ident;
                next_ident_next  = next_ident + IDENT_W'(1);
                post_valid_next  = 1'b1;
                post_exp_next    = sum_exp;
              end
            end
            OP_CANCEL: begin
              if (slot_is_valid && (ram_rdata.ident == cur.cancel_id)) begin
                slot_valid_next = slot_valid & ~rd_bit;
                found_next      = 1'b1;
                post_valid_next = 1'b0;
              end
            end
            OP_TICK: begin
              if (slot_is_valid && (ram_rdata.expiry <= clock_ms) &&
                  (fire_cnt < FIRE_W'(MAX_RESULTS))) begin
                fired_mask_next = fired_mask | rd_bit;
                fire_cnt_next   = fire_cnt + FIRE_W'(1);
                if (ram_rdata.period != '0) begin
                  ram_we           = 1'b1;
                  ram_wdata.expiry = sum_exp;
                  post_exp_next    = sum_exp;
                end else begin
                  slot_valid_next = slot_valid & ~rd_bit;
                  post_valid_next = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
        // Compare stage: keep the nearest expiry of the updated table.
        if (ev_vld && post_valid && (!any_valid || (post_exp < nearest))) begin
          nearest_next   = post_exp;
          any_valid_next = 1'b1;
        end
        if ((idx == CNT_W'(TIMER_SLOTS)) && !rd_vld && !ev_vld) begin
          state_next = S_CALC;
        end
      end

      S_CALC: begin
        diff_next    = sub_full[TIME_W-1:0];
        due_now_next = sub_full[TIME_W] || (sub_full[TIME_W-1:0] == '0);
        state_next   = S_CLAMP;
      end

      S_CLAMP: begin
        wait_ms_next = wait_value;
        if ((cur.opcode == OP_TICK) && (fire_cnt != '0)) begin
          idx_next   = '0;
          state_next = S_EMIT;
        end else begin
          result_next.timer_ref    = '0;
          result_next.expired      = 1'b0;
          result_next.status       = STATUS_OK;
          result_next.next_wait_ms = wait_value;
          result_next.last         = 1'b1;
          if (cur.opcode == OP_ADD) begin
            if (found) begin
              result_next.timer_ref = result_id;
            end else begin
              result_next.status = STATUS_FULL;
            end
          end else if ((cur.opcode == OP_CANCEL) && !found) begin
            result_next.status = STATUS_NO_MATCH;
          end
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end

      S_EMIT: begin
        // Walk the slots again and report each one that fired, in order.
        if (rd_vld && fired_mask[rd_idx]) begin
          fired_mask_next          = fired_mask & ~rd_bit;
          result_next.timer_ref    = ram_rdata.ident;
          result_next.expired      = 1'b1;
          result_next.status       = STATUS_OK;
          result_next.next_wait_ms = wait_ms;
          result_next.last         = ((fired_mask & ~rd_bit) == '0);
          result_valid_next        = 1'b1;
          if ((fired_mask & ~rd_bit) == '0) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      rd_vld       <= 1'b0;
      ev_vld       <= 1'b0;
      slot_valid   <= '0;
      clock_ms     <= '0;
      next_ident   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      rd_vld       <= rd_vld_next;
      ev_vld       <= ev_vld_next;
      slot_valid   <= slot_valid_next;
      clock_ms     <= clock_ms_next;
      next_ident   <= next_ident_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    rd_idx     <= rd_idx_next;
    post_valid <= post_valid_next;
    post_exp   <= post_exp_next;
    nearest    <= nearest_next;
    any_valid  <= any_valid_next;
    fired_mask <= fired_mask_next;
    fire_cnt   <= fire_cnt_next;
    found      <= found_next;
    result_id  <= result_id_next;
    diff       <= diff_next;
    due_now    <= due_now_next;
    wait_ms    <= wait_ms_next;
    result     <= result_next;
  end

endmodule

FILE: rtl/core/mtt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module mtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/millisecond_timer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Millisecond timer table testbench
// Sends add, cancel, tick and unused-opcode items and checks every result,
// field by field, against a timer table predictor kept inside the bench.
// ----------------------------------------------------------------------------
module millisecond_timer_table_tb;
  import mtt_pkg::*;

  // The random part starts no new sequence once this many non-ignored items have been taken.
  localparam int TOTAL_ITEMS  = 260;
  // The longest quiet stretch of a correct run is one item's two sweeps
  // plus the longest sender gap.
  localparam int QUIET_LIMIT  = 2000;
  // After the last expected result, this many cycles catch stray results.
  localparam int DRAIN_CYCLES = 48;

  typedef struct {
    item_t   stim;
    bit      known;
    result_t want;
  } plan_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  result_t result;
  logic    result_valid;

  millisecond_timer_table dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid)
  );

  always #10 clk = ~clk;

  // Predictor copy of the timer table.
  logic               armed    [TIMER_SLOTS];
  logic [IDENT_W-1:0] idents   [TIMER_SLOTS];
  logic [TIME_W-1:0]  expiries [TIMER_SLOTS];
  logic [DELAY_W-1:0] periods  [TIMER_SLOTS];
  logic [TIME_W-1:0]  now_ms;
  logic [IDENT_W-1:0] fresh_ident;

  // Results the table still owes, oldest first.
  result_t timer_outcomes[$];

  int mismatches;
  int items_sent;
  int quiet;
  bit steady;

  // Coverage tallies for the closing summary.
  int adds_seen, full_seen, cancels_seen, misses_seen, ticks_seen;
  int fired_total, widest_tick;

  // Wait until the nearest armed expiry, as every result reports it.
  function automatic logic [WAIT_W-1:0] nearest_wait();
    logic [TIME_W-1:0] soonest;
    bit                any;
    soonest = '0;
    any     = 1'b0;
    for (int s = 0; s < TIMER_SLOTS; s++) begin
      if (armed[s] && (!any || expiries[s] < soonest)) begin
        soonest = expiries[s];
        any     = 1'b1;
      end
    end
    if (!any) return EMPTY_WAIT_MS;
    if (soonest <= now_ms) return '0;
    if (soonest - now_ms > MAX_WAIT_MS) return MAX_WAIT_MS;
    return WAIT_W'(soonest - now_ms);
  endfunction

  // Applies one accepted item to the predictor and queues the results it owes.
  function automatic void advance_table(item_t it);
    result_t            base;
    logic [IDENT_W-1:0] fired[$];
    bit                 placed;
    bit                 hit;
    base      = '0;
    base.last = 1'b1;
    placed    = 1'b0;
    hit       = 1'b0;
    case (it.opcode)
      OP_ADD: begin
        adds_seen++;
        // The lowest free slot takes the new timer.
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (!placed && !armed[s]) begin
            placed         = 1'b1;
            armed[s]       = 1'b1;
            idents[s]      = fresh_ident;
            expiries[s]    = now_ms + TIME_W'(it.interval);
            periods[s]     = it.repeat_req ? it.interval : '0;
            base.timer_ref = fresh_ident;
            fresh_ident    = fresh_ident + 1'b1;
          end
        end
        if (!placed) begin
          base.status = STATUS_FULL;
          full_seen++;
        end
        base.next_wait_ms = nearest_wait();
        timer_outcomes.insert(timer_outcomes.size(), base);
      end
      OP_CANCEL: begin
        cancels_seen++;
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (armed[s] && idents[s] == it.cancel_id) begin
            armed[s] = 1'b0;
            hit      = 1'b1;
          end
        end
        if (!hit) begin
          base.status = STATUS_NO_MATCH;
          misses_seen++;
        end
        base.next_wait_ms = nearest_wait();
        timer_outcomes.insert(timer_outcomes.size(), base);
      end
      OP_TICK: begin
        ticks_seen++;
        now_ms = now_ms + 1'b1;
        for (int s = 0; s < TIMER_SLOTS; s++) begin
          if (armed[s] && expiries[s] <= now_ms && fired.size() < MAX_RESULTS) begin
            fired.insert(fired.size(), idents[s]);
            if (periods[s] != '0) expiries[s] = now_ms + TIME_W'(periods[s]);
            else armed[s] = 1'b0;
          end
        end
        base.next_wait_ms = nearest_wait();
        if (fired.size() == 0) begin
          timer_outcomes.insert(timer_outcomes.size(), base);
        end else begin
          fired_total += fired.size();
          if (fired.size() > widest_tick) widest_tick = fired.size();
          foreach (fired[k]) begin
            base.timer_ref = fired[k];
            base.expired   = 1'b1;
            base.last      = (k == fired.size() - 1);
            timer_outcomes.insert(timer_outcomes.size(), base);
          end
        end
      end
      default: begin
        base.next_wait_ms = nearest_wait();
        timer_outcomes.insert(timer_outcomes.size(), base);
      end
    endcase
  endfunction

  // An item of the given kind with every field filled at random.
  function automatic item_t scrambled(opcode_t op);
    item_t it;
    it.opcode     = op;
    it.interval   = DELAY_W'($urandom);
    it.repeat_req = 1'($urandom_range(0, 1));
    it.cancel_id  = $urandom;
    return it;
  endfunction

  // The id of a random armed timer, or a random id when none is armed.
  function automatic logic [IDENT_W-1:0] live_ident();
    logic [IDENT_W-1:0] pool[$];
    foreach (armed[s]) begin
      if (armed[s]) pool.insert(pool.size(), idents[s]);
    end
    if (pool.size() == 0) return $urandom;
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function automatic result_t outcome(logic [IDENT_W-1:0] id, logic fired,
                                      logic [1:0] status, logic [WAIT_W-1:0] wait_ms);
    result_t r;
    r.timer_ref    = id;
    r.expired      = fired;
    r.status       = status;
    r.next_wait_ms = wait_ms;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic plan_row_t row(opcode_t op, logic [DELAY_W-1:0] delay,
                                    logic rep, logic [IDENT_W-1:0] cid,
                                    bit known = 1'b0, result_t want = '0);
    plan_row_t p;
    p.stim.opcode     = op;
    p.stim.interval   = delay;
    p.stim.repeat_req = rep;
    p.stim.cancel_id  = cid;
    p.known           = known;
    p.want            = want;
    return p;
  endfunction

  // Offers one item after a random gap (none when steady) and returns at the edge that takes it.
  // start stays high when the next item follows with no gap.
  task automatic issue(item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    advance_table(it);
    if (it.opcode != OP_NONE) items_sent++;
  endtask

  // Holds the sender off until every owed result has come out.
  task automatic hold_until_drained();
    start <= 1'b0;
    while (timer_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string field, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Results cannot be held off, so each one is compared on the edge that
  // ends its cycle.
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && result_valid) begin
      if (timer_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result %h arrived with nothing expected", $time, result);
      end else begin
        want = timer_outcomes.pop_front();
        check_field("timer_ref", want.timer_ref, result.timer_ref);
        check_field("expired", want.expired, result.expired);
        check_field("status", want.status, result.status);
        check_field("next_wait_ms", want.next_wait_ms, result.next_wait_ms);
        check_field("last", want.last, result.last);
      end
    end
  end

  // Watchdog: any taken item or result shows the table is alive.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results still owed",
               $time, QUIET_LIMIT, timer_outcomes.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    plan_row_t          plan[$];
    item_t              it;
    logic [IDENT_W-1:0] doomed[$];
    logic [DELAY_W-1:0] shared_delay;
    int                 spare;
    int                 pick;

    clk   = 1'b0;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    quiet = 0;
    steady = 1'b0;
    mismatches = 0;
    items_sent = 0;
    adds_seen = 0; full_seen = 0; cancels_seen = 0; misses_seen = 0;
    ticks_seen = 0; fired_total = 0; widest_tick = 0;
    now_ms      = '0;
    fresh_ident = '0;
    foreach (armed[s]) begin
      armed[s]    = 1'b0;
      idents[s]   = '0;
      expiries[s] = '0;
      periods[s]  = '0;
    end

    // Directed part. The first rows read straight off the spec: an empty
    // table reports a 100 ms wait, the unused opcode and a cancel of an
    // unknown id leave it alone, a zero delay is due at once and stays
    // one-shot even with repeat set, and a full-scale delay clamps the wait.
    plan.insert(plan.size(), row(OP_TICK, '0, 1'b0, '0, 1'b1,
                       outcome('0, 1'b0, STATUS_OK, EMPTY_WAIT_MS)));
    plan.insert(plan.size(), row(OP_NONE, '1, 1'b1, '1, 1'b1,
                       outcome('0, 1'b0, STATUS_OK, EMPTY_WAIT_MS)));
    plan.insert(plan.size(), row(OP_CANCEL, '0, 1'b0, '1, 1'b1,
                       outcome('0, 1'b0, STATUS_NO_MATCH, EMPTY_WAIT_MS)));
    plan.insert(plan.size(), row(OP_ADD, '0, 1'b1, '0, 1'b1,
                       outcome(32'd0, 1'b0, STATUS_OK, '0)));
    plan.insert(plan.size(), row(OP_ADD, '1, 1'b0, '0, 1'b1,
                       outcome(32'd1, 1'b0, STATUS_OK, '0)));
    plan.insert(plan.size(), row(OP_TICK, '0, 1'b0, '0, 1'b1,
                       outcome(32'd0, 1'b1, STATUS_OK, MAX_WAIT_MS)));
    // The rest goes to the predictor: a periodic timer that re-arms, two
    // timers due on the same tick, cancels that hit and miss.
    plan.insert(plan.size(), row(OP_ADD, 24'd3, 1'b1, '0));
    plan.insert(plan.size(), row(OP_ADD, 24'd1000, 1'b0, '0));
    plan.insert(plan.size(), row(OP_TICK, '0, 1'b0, '0));
    plan.insert(plan.size(), row(OP_TICK, '0, 1'b0, '0));
    plan.insert(plan.size(), row(OP_TICK, '0, 1'b0, '0));
    plan.insert(plan.size(), row(OP_TICK, '0, 1'b0, '0));
    plan.insert(plan.size(), row(OP_CANCEL, '0, 1'b0, 32'd1));
    plan.insert(plan.size(), row(OP_CANCEL, '0, 1'b0, 32'd1));
    plan.insert(plan.size(), row(OP_ADD, 24'd1, 1'b1, '0));
    plan.insert(plan.size(), row(OP_ADD, 24'd1, 1'b0, '0));
    plan.insert(plan.size(), row(OP_TICK, '0, 1'b0, '0));
    plan.insert(plan.size(), row(OP_TICK, '0, 1'b0, '0));
    plan.insert(plan.size(), row(OP_CANCEL, '0, 1'b0, 32'd2));
    plan.insert(plan.size(), row(OP_CANCEL, '0, 1'b0, 32'd4));
    plan.insert(plan.size(), row(OP_ADD, 24'd999, 1'b1, '0));
    plan.insert(plan.size(), row(OP_CANCEL, '0, 1'b0, 32'd0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      issue(plan[k].stim);
      if (plan[k].known) begin
        void'(timer_outcomes.pop_back());
        timer_outcomes.insert(timer_outcomes.size(), plan[k].want);
      end
    end
    hold_until_drained();

    // Random part, built from short sequences: bursts that fill the table
    // with timers due on the same tick, sweeps that cancel every armed
    // timer, and mixed runs of all item kinds.
    while (items_sent < TOTAL_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) hold_until_drained();
      case ($urandom_range(0, 9))
        0, 1: begin
          // Fill every free slot, overrun by one or two adds, then tick until
          // the whole batch has fired.
          shared_delay = DELAY_W'($urandom_range(0, 4));
          spare = 0;
          foreach (armed[s]) begin
            if (!armed[s]) spare++;
          end
          repeat (spare + $urandom_range(1, 2)) begin
            it = scrambled(OP_ADD);
            it.interval = shared_delay;
            issue(it);
          end
          repeat (shared_delay + 2) issue(scrambled(OP_TICK));
        end
        2, 3: begin
          doomed = {};
          foreach (armed[s]) begin
            if (armed[s]) doomed.insert(doomed.size(), idents[s]);
          end
          foreach (doomed[k]) begin
            it = scrambled(OP_CANCEL);
            it.cancel_id = doomed[k];
            issue(it);
          end
          issue(scrambled(OP_CANCEL));
        end
        default: begin
          repeat ($urandom_range(8, 20)) begin
            pick = $urandom_range(0, 19);
            if (pick < 9) begin
              it = scrambled(OP_TICK);
            end else if (pick < 15) begin
              // Mostly short delays so timers fire; sometimes any 24-bit delay.
              it = scrambled(OP_ADD);
              if ($urandom_range(0, 5) != 0) it.interval = DELAY_W'($urandom_range(0, 12));
            end else if (pick < 19) begin
              it = scrambled(OP_CANCEL);
              if ($urandom_range(0, 2) != 0) begin
                it.cancel_id = live_ident();
              end else if ($urandom_range(0, 1) != 0) begin
                it.cancel_id = fresh_ident - IDENT_W'($urandom_range(1, 4));
              end
            end else begin
              it = scrambled(OP_NONE);
            end
            issue(it);
          end
        end
      endcase
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $write("Covered %0d items: %0d adds (%0d on a full table), ",
           items_sent, adds_seen, full_seen);
    $display("%0d cancels (%0d unmatched), %0d ticks",
             cancels_seen, misses_seen, ticks_seen);
    $display("%0d timers fired, up to %0d on a single tick; %0d field mismatches",
             fired_total, widest_tick, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
